FILE: sv/clut_pkg.sv
// clut_pkg: shared widths, calibration tables and microcode for the
// conductivity lookup interpolator; no dependencies
`timescale 1ns / 1ps

package clut_pkg;

    localparam int ADC_W       = 12;
    localparam int AVG_W       = 20;
    localparam int TDS_W       = 15;
    localparam int SEG_W       = 7;
    localparam int TDS_PT_W    = 11;
    localparam int STORED_ROWS = 112;
    localparam int NUM_W       = 35;
    localparam int QUO_W       = 15;
    localparam int BIT_W       = 4;
    localparam int SHIFT_W     = 3;
    localparam int APB_AW      = 3;
    localparam int APB_DW      = 32;

    // register selects, taken from paddr bit 2
    localparam logic REG_ADC_SHIFT = 1'b0;
    localparam logic REG_TDS_SHIFT = 1'b1;

    localparam logic [SHIFT_W-1:0] ADC_SHIFT_RST = 3'd3;
    localparam logic [SHIFT_W-1:0] TDS_SHIFT_RST = 3'd4;

    // descending adc breakpoints
    localparam logic [ADC_W-1:0] ADC_POINTS [0:STORED_ROWS-1] = '{
        12'd4000, 12'd3942, 12'd3886, 12'd3793, 12'd3682, 12'd3586, 12'd3494, 12'd3424,
        12'd3335, 12'd3263, 12'd3183, 12'd3090, 12'd2998, 12'd2951, 12'd2903, 12'd2854,
        12'd2784, 12'd2735, 12'd2663, 12'd2615, 12'd2578, 12'd2530, 12'd2487, 12'd2422,
        12'd2367, 12'd2336, 12'd2272, 12'd2223, 12'd2166, 12'd2130, 12'd2102, 12'd2055,
        12'd2016, 12'd1984, 12'd1956, 12'd1926, 12'd1885, 12'd1855, 12'd1836, 12'd1808,
        12'd1770, 12'd1746, 12'd1718, 12'd1700, 12'd1679, 12'd1647, 12'd1623, 12'd1607,
        12'd1600, 12'd1596, 12'd1571, 12'd1558, 12'd1543, 12'd1510, 12'd1479, 12'd1462,
        12'd1440, 12'd1414, 12'd1380, 12'd1359, 12'd1334, 12'd1318, 12'd1302, 12'd1286,
        12'd1260, 12'd1248, 12'd1234, 12'd1218, 12'd1215, 12'd1206, 12'd1186, 12'd1170,
        12'd1147, 12'd1132, 12'd1120, 12'd1107, 12'd1094, 12'd1086, 12'd1046, 12'd1037,
        12'd1030, 12'd1018, 12'd1007, 12'd1000, 12'd992,  12'd982,  12'd973,  12'd964,
        12'd958,  12'd954,  12'd945,  12'd927,  12'd897,  12'd864,  12'd840,  12'd831,
        12'd822,  12'd813,  12'd804,  12'd797,  12'd784,  12'd773,  12'd764,  12'd747,
        12'd739,  12'd729,  12'd727,  12'd727,  12'd717,  12'd706,  12'd702,  12'd696
    };

    // ascending tds breakpoints, whole units
    localparam logic [TDS_PT_W-1:0] TDS_POINTS [0:STORED_ROWS-1] = '{
        11'd5,    11'd6,    11'd10,   11'd15,   11'd20,   11'd27,   11'd32,   11'd38,
        11'd43,   11'd47,   11'd54,   11'd61,   11'd69,   11'd74,   11'd77,   11'd83,
        11'd89,   11'd95,   11'd100,  11'd106,  11'd113,  11'd117,  11'd123,  11'd128,
        11'd138,  11'd147,  11'd156,  11'd164,  11'd171,  11'd179,  11'd186,  11'd195,
        11'd202,  11'd208,  11'd217,  11'd226,  11'd233,  11'd241,  11'd249,  11'd258,
        11'd266,  11'd274,  11'd283,  11'd290,  11'd300,  11'd307,  11'd314,  11'd319,
        11'd327,  11'd333,  11'd337,  11'd348,  11'd360,  11'd376,  11'd395,  11'd408,
        11'd423,  11'd433,  11'd443,  11'd462,  11'd473,  11'd483,  11'd492,  11'd505,
        11'd517,  11'd529,  11'd538,  11'd548,  11'd558,  11'd562,  11'd577,  11'd596,
        11'd614,  11'd628,  11'd642,  11'd658,  11'd668,  11'd680,  11'd687,  11'd696,
        11'd704,  11'd713,  11'd724,  11'd735,  11'd750,  11'd761,  11'd773,  11'd785,
        11'd802,  11'd810,  11'd825,  11'd856,  11'd891,  11'd950,  11'd955,  11'd1020,
        11'd1050, 11'd1080, 11'd1100, 11'd1130, 11'd1150, 11'd1200, 11'd1220, 11'd1240,
        11'd1260, 11'd1300, 11'd1350, 11'd1390, 11'd1440, 11'd1450, 11'd1470, 11'd1520
    };

    function automatic logic [ADC_W-1:0] adc_point(input logic [SEG_W-1:0] idx);
        logic [ADC_W-1:0] val;
        val = '0;
        if (int'(idx) < STORED_ROWS)
        begin
            val = ADC_POINTS[idx];
        end
        return val;
    endfunction

    function automatic logic [TDS_PT_W-1:0] tds_point(input logic [SEG_W-1:0] idx);
        logic [TDS_PT_W-1:0] val;
        val = '0;
        if (int'(idx) < STORED_ROWS)
        begin
            val = TDS_POINTS[idx];
        end
        return val;
    endfunction

    // sequencer steps
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_AVG,
        ST_SEARCH,
        ST_FETCH,
        ST_MUL,
        ST_DIV,
        ST_EMIT
    } step_t;

    typedef enum logic [2:0] {
        OP_TAKE,
        OP_AVERAGE,
        OP_SEARCH,
        OP_FETCH,
        OP_MULTIPLY,
        OP_DIVIDE,
        OP_EMIT
    } op_t;

    // condition that lets the step counter move on
    typedef enum logic [2:0] {
        CD_ALWAYS,
        CD_INPUT,
        CD_SEG_FOUND,
        CD_DIV_DONE,
        CD_OUT_FREE
    } cond_t;

    typedef struct packed {
        op_t   op;
        cond_t cond;
        step_t next;
    } ucode_t;

    function automatic ucode_t ucode_rom(input step_t s);
        ucode_t uc;
        case (s)
            ST_IDLE:   uc = '{op: OP_TAKE,     cond: CD_INPUT,     next: ST_AVG};
            ST_AVG:    uc = '{op: OP_AVERAGE,  cond: CD_ALWAYS,    next: ST_SEARCH};
            ST_SEARCH: uc = '{op: OP_SEARCH,   cond: CD_SEG_FOUND, next: ST_FETCH};
            ST_FETCH:  uc = '{op: OP_FETCH,    cond: CD_ALWAYS,    next: ST_MUL};
            ST_MUL:    uc = '{op: OP_MULTIPLY, cond: CD_ALWAYS,    next: ST_DIV};
            ST_DIV:    uc = '{op: OP_DIVIDE,   cond: CD_DIV_DONE,  next: ST_EMIT};
            ST_EMIT:   uc = '{op: OP_EMIT,     cond: CD_OUT_FREE,  next: ST_IDLE};
            default:   uc = '{op: OP_TAKE,     cond: CD_INPUT,     next: ST_AVG};
        endcase
        return uc;
    endfunction

endpackage

FILE: sv/clut_if.sv
// clut_if: valid/ready channel interfaces for samples and results
// depends on clut_pkg for field widths
`timescale 1ns / 1ps

interface clut_sample_if;
    logic                        valid;
    logic                        ready;
    logic [clut_pkg::ADC_W-1:0]  adc_sample;

    modport source (output valid, output adc_sample, input ready);
    modport sink   (input valid, input adc_sample, output ready);
endinterface

interface clut_result_if;
    logic                        valid;
    logic                        ready;
    logic [clut_pkg::AVG_W-1:0]  adc_average_q8;
    logic [clut_pkg::TDS_W-1:0]  tds_instant_q4;
    logic [clut_pkg::TDS_W-1:0]  tds_average_q4;
    logic [clut_pkg::SEG_W-1:0]  segment_index;

    modport source (output valid, output adc_average_q8, output tds_instant_q4,
                    output tds_average_q4, output segment_index, input ready);
    modport sink   (input valid, input adc_average_q8, input tds_instant_q4,
                    input tds_average_q4, input segment_index, output ready);
endinterface

FILE: sv/conductivity_lut_interpolator.sv
// conductivity_lut_interpolator: adc averaging, table interpolation to tds
// and tds averaging; depends on clut_pkg and clut_if
//
// usage
// - samples channel takes one 12-bit adc reading per item; results channel
//   gives one item per sample: q8 adc average, instant and averaged q4 tds,
//   and the table segment used
// - the first sample after reset loads the adc average directly; later ones
//   blend in with divisor 2^adc_filter_shift. the tds average starts at zero
//   and blends with divisor 2^tds_filter_shift
// - apb port: shift registers at byte 0 (adc) and byte 4 (tds), 3 bits each,
//   to be written only while the block is idle, which the block does not enforce
// - a microcoded step counter runs each item: accept, average, segment
//   walk (one table row per cycle), fetch, multiply, 15-step restoring
//   divide, emit
// - the segment walk stops at the first row pair that holds the average, or
//   at the last segment when the average sits on the table top and every
//   row is walked
// - one item worked on at a time; with a free receiver the next sample can
//   be taken in the cycle after the emit
// - the segment walk is what makes the time per item vary
// - a stalled receiver holds the result in the output register; the next
//   sample may be accepted and worked on meanwhile, but its emit step waits
// - reset clears the averages, the primed flag, both shifts to 3 and 4,
//   the step counter and the output valid
`timescale 1ns / 1ps

module conductivity_lut_interpolator #(
    parameter int TABLE_ENTRIES = 112
) (
    input  logic                               clk,
    input  logic                               rst_n,
    clut_sample_if.sink                        samples,
    clut_result_if.source                      results,
    input  logic                               psel,
    input  logic                               penable,
    input  logic                               pwrite,
    input  logic [clut_pkg::APB_AW-1:0]        paddr,
    input  logic [clut_pkg::APB_DW-1:0]        pwdata,
    output logic [clut_pkg::APB_DW-1:0]        prdata,
    output logic                               pready
);

    // rows actually used from the stored table
    localparam int USED_ROWS = (TABLE_ENTRIES < 2) ? 2 :
        ((TABLE_ENTRIES > clut_pkg::STORED_ROWS) ? clut_pkg::STORED_ROWS : TABLE_ENTRIES);
    localparam logic [clut_pkg::SEG_W-1:0] LAST_SEG = clut_pkg::SEG_W'(USED_ROWS - 2);
    localparam logic [clut_pkg::SEG_W-1:0] LAST_ROW = clut_pkg::SEG_W'(USED_ROWS - 1);

    // clamp limits of the adc average and of the interpolated tds
    localparam logic [clut_pkg::AVG_W-1:0] TOP_Q8 = {clut_pkg::ADC_POINTS[0], 8'd0};
    localparam logic [clut_pkg::AVG_W-1:0] BOT_Q8 =
        {clut_pkg::ADC_POINTS[USED_ROWS-1], 8'd0};
    localparam logic [clut_pkg::TDS_W-1:0] TMIN_Q4 = {clut_pkg::TDS_POINTS[0], 4'd0};
    localparam logic [clut_pkg::TDS_W-1:0] TMAX_Q4 =
        {clut_pkg::TDS_POINTS[USED_ROWS-1], 4'd0};
    localparam logic [clut_pkg::BIT_W-1:0] TOP_BIT = clut_pkg::BIT_W'(clut_pkg::QUO_W - 1);

    // ------------------------------------------------------------------
    // registers
    // ------------------------------------------------------------------
    clut_pkg::step_t                  step_reg, step_next;
    logic                             primed_reg, primed_next;
    logic [clut_pkg::SHIFT_W-1:0]     adc_shift_reg, adc_shift_next;
    logic [clut_pkg::SHIFT_W-1:0]     tds_shift_reg, tds_shift_next;
    logic [clut_pkg::AVG_W-1:0]       adc_avg_reg, adc_avg_next;
    logic [clut_pkg::TDS_W-1:0]       tds_avg_reg, tds_avg_next;
    logic                             out_valid_reg, out_valid_next;

    logic [clut_pkg::ADC_W-1:0]       sample_reg, sample_next;
    logic [clut_pkg::AVG_W-1:0]       v_reg, v_next;
    logic [clut_pkg::SEG_W-1:0]       k_reg, k_next;
    logic [clut_pkg::SEG_W-1:0]       seg_reg, seg_next;
    logic [clut_pkg::TDS_W-1:0]       t0_reg, t0_next;
    logic [clut_pkg::TDS_W-1:0]       dt_reg, dt_next;
    logic [clut_pkg::AVG_W-1:0]       r_reg, r_next;
    logic [clut_pkg::AVG_W-1:0]       den_reg, den_next;
    logic [clut_pkg::NUM_W-1:0]       num_reg, num_next;
    logic [clut_pkg::QUO_W-1:0]       quo_reg, quo_next;
    logic [clut_pkg::BIT_W-1:0]       bit_reg, bit_next;

    logic [clut_pkg::AVG_W-1:0]       out_adc_reg, out_adc_next;
    logic [clut_pkg::TDS_W-1:0]       out_tds_reg, out_tds_next;
    logic [clut_pkg::TDS_W-1:0]       out_tavg_reg, out_tavg_next;
    logic [clut_pkg::SEG_W-1:0]       out_seg_reg, out_seg_next;

    // ------------------------------------------------------------------
    // microcode and condition
    // ------------------------------------------------------------------
    clut_pkg::ucode_t                 uc;
    logic                             in_fire;
    logic                             out_free;
    logic                             seg_hit;
    logic                             seg_last;
    logic                             proceed;

    assign uc       = clut_pkg::ucode_rom(step_reg);
    assign in_fire  = samples.valid && samples.ready;
    assign out_free = !out_valid_reg || results.ready;

    always_comb
    begin
        case (uc.cond)
            clut_pkg::CD_ALWAYS:    proceed = 1'b1;
            clut_pkg::CD_INPUT:     proceed = in_fire;
            clut_pkg::CD_SEG_FOUND: proceed = seg_hit || seg_last;
            clut_pkg::CD_DIV_DONE:  proceed = (bit_reg == '0);
            clut_pkg::CD_OUT_FREE:  proceed = out_free;
            default:                proceed = 1'b1;
        endcase
    end

    // next step
    always_comb
    begin
        step_next = proceed ? uc.next : step_reg;
    end

    // control outputs of the current word
    logic en_take, en_avg, en_search, en_fetch, en_mul, en_div, en_emit;

    always_comb
    begin
        en_take   = 1'b0;
        en_avg    = 1'b0;
        en_search = 1'b0;
        en_fetch  = 1'b0;
        en_mul    = 1'b0;
        en_div    = 1'b0;
        en_emit   = 1'b0;
        case (uc.op)
            clut_pkg::OP_TAKE:     en_take   = 1'b1;
            clut_pkg::OP_AVERAGE:  en_avg    = 1'b1;
            clut_pkg::OP_SEARCH:   en_search = 1'b1;
            clut_pkg::OP_FETCH:    en_fetch  = 1'b1;
            clut_pkg::OP_MULTIPLY: en_mul    = 1'b1;
            clut_pkg::OP_DIVIDE:   en_div    = 1'b1;
            clut_pkg::OP_EMIT:     en_emit   = 1'b1;
            default:               en_take   = 1'b1;
        endcase
    end

    assign samples.ready = en_take;

    // ------------------------------------------------------------------
    // datapath
    // ------------------------------------------------------------------

    // adc average: avg - avg>>s + x>>s, with one spare bit for the sum
    logic [clut_pkg::AVG_W-1:0] xq;
    logic [clut_pkg::AVG_W:0]   adc_ema;
    logic [clut_pkg::AVG_W-1:0] adc_new;
    logic [clut_pkg::AVG_W-1:0] v_clamped;

    assign xq      = {sample_reg, 8'd0};
    assign adc_ema = {1'b0, adc_avg_reg} - ({1'b0, adc_avg_reg} >> adc_shift_reg)
                   + ({1'b0, xq} >> adc_shift_reg);
    assign adc_new = primed_reg ? adc_ema[clut_pkg::AVG_W-1:0] : xq;

    always_comb
    begin
        v_clamped = adc_new;
        if (adc_new > TOP_Q8)
        begin
            v_clamped = TOP_Q8;
        end
        if (adc_new < BOT_Q8)
        begin
            v_clamped = BOT_Q8;
        end
    end

    // segment walk: rows k and k+1, compared on the integer part of v
    logic [clut_pkg::SEG_W-1:0] k_plus;
    logic [clut_pkg::ADC_W-1:0] walk_hi;
    logic [clut_pkg::ADC_W-1:0] walk_lo;
    logic [clut_pkg::ADC_W-1:0] v_int;

    assign k_plus   = k_reg + clut_pkg::SEG_W'(1);
    assign walk_hi  = clut_pkg::adc_point(k_reg);
    assign walk_lo  = clut_pkg::adc_point(k_plus);
    assign v_int    = v_reg[clut_pkg::AVG_W-1:8];
    assign seg_hit  = (v_int >= walk_lo) && (v_int < walk_hi);
    assign seg_last = (k_reg == LAST_SEG);

    // segment end points
    logic [clut_pkg::SEG_W-1:0]    seg_plus;
    logic [clut_pkg::ADC_W-1:0]    seg_hi;
    logic [clut_pkg::ADC_W-1:0]    seg_lo;
    logic [clut_pkg::TDS_W-1:0]    seg_t0;
    logic [clut_pkg::TDS_W-1:0]    seg_t1;
    logic [clut_pkg::ADC_W-1:0]    seg_span;

    assign seg_plus = seg_reg + clut_pkg::SEG_W'(1);
    assign seg_hi   = clut_pkg::adc_point(seg_reg);
    assign seg_lo   = clut_pkg::adc_point(seg_plus);
    assign seg_t0   = {clut_pkg::tds_point(seg_reg), 4'd0};
    assign seg_t1   = {clut_pkg::tds_point(seg_plus), 4'd0};
    assign seg_span = seg_hi - seg_lo;

    // restoring divide, one quotient bit a step
    logic [clut_pkg::NUM_W-1:0] den_sh;
    logic [clut_pkg::NUM_W:0]   div_diff;
    logic                       div_ge;

    assign den_sh   = clut_pkg::NUM_W'(den_reg) << bit_reg;
    assign div_diff = {1'b0, num_reg} - {1'b0, den_sh};
    assign div_ge   = !div_diff[clut_pkg::NUM_W];

    // result: add quotient, clamp to the table ends, then tds average
    logic [clut_pkg::TDS_W:0]   tds_sum;
    logic [clut_pkg::TDS_W:0]   tds_raw;
    logic [clut_pkg::TDS_W-1:0] tds_val;
    logic [clut_pkg::TDS_W:0]   tds_ema;

    assign tds_sum = {1'b0, t0_reg} + {1'b0, quo_reg};
    // zero-width segment keeps the lower row value
    assign tds_raw = (den_reg == '0) ? {1'b0, t0_reg} : tds_sum;

    always_comb
    begin
        tds_val = tds_raw[clut_pkg::TDS_W-1:0];
        if (tds_raw > {1'b0, TMAX_Q4})
        begin
            tds_val = TMAX_Q4;
        end
        if (tds_raw < {1'b0, TMIN_Q4})
        begin
            tds_val = TMIN_Q4;
        end
    end

    assign tds_ema = {1'b0, tds_avg_reg} - ({1'b0, tds_avg_reg} >> tds_shift_reg)
                   + ({1'b0, tds_val} >> tds_shift_reg);

    // next values of the datapath
    always_comb
    begin
        primed_next   = primed_reg;
        adc_avg_next  = adc_avg_reg;
        tds_avg_next  = tds_avg_reg;
        out_valid_next = out_valid_reg;
        sample_next   = sample_reg;
        v_next        = v_reg;
        k_next        = k_reg;
        seg_next      = seg_reg;
        t0_next       = t0_reg;
        dt_next       = dt_reg;
        r_next        = r_reg;
        den_next      = den_reg;
        num_next      = num_reg;
        quo_next      = quo_reg;
        bit_next      = bit_reg;
        out_adc_next  = out_adc_reg;
        out_tds_next  = out_tds_reg;
        out_tavg_next = out_tavg_reg;
        out_seg_next  = out_seg_reg;

        if (out_valid_reg && results.ready)
        begin
            out_valid_next = 1'b0;
        end

        if (en_take && in_fire)
        begin
            sample_next = samples.adc_sample;
        end

        if (en_avg)
        begin
            adc_avg_next = adc_new;
            primed_next  = 1'b1;
            v_next       = v_clamped;
            k_next       = '0;
        end

        if (en_search)
        begin
            if (seg_hit)
            begin
                seg_next = k_reg;
            end
            else if (seg_last)
            begin
                // top of the table matches no segment
                seg_next = '0;
            end
            else
            begin
                k_next = k_plus;
            end
        end

        if (en_fetch)
        begin
            t0_next  = seg_t0;
            dt_next  = seg_t1 - seg_t0;
            den_next = {seg_span, 8'd0};
            r_next   = {seg_hi, 8'd0} - v_reg;
        end

        if (en_mul)
        begin
            num_next = clut_pkg::NUM_W'(dt_reg) * clut_pkg::NUM_W'(r_reg);
            quo_next = '0;
            bit_next = TOP_BIT;
        end

        if (en_div)
        begin
            if (div_ge)
            begin
                num_next          = div_diff[clut_pkg::NUM_W-1:0];
                quo_next[bit_reg] = 1'b1;
            end
            if (bit_reg != '0)
            begin
                bit_next = bit_reg - clut_pkg::BIT_W'(1);
            end
        end

        if (en_emit && out_free)
        begin
            tds_avg_next   = tds_ema[clut_pkg::TDS_W-1:0];
            out_valid_next = 1'b1;
            out_adc_next   = adc_avg_reg;
            out_tds_next   = tds_val;
            out_tavg_next  = tds_ema[clut_pkg::TDS_W-1:0];
            out_seg_next   = seg_reg;
        end
    end

    // ------------------------------------------------------------------
    // configuration port
    // ------------------------------------------------------------------
    logic cfg_wr;
    logic cfg_sel;

    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite && pready;
    assign cfg_sel = paddr[clut_pkg::APB_AW-1];

    always_comb
    begin
        adc_shift_next = adc_shift_reg;
        tds_shift_next = tds_shift_reg;
        if (cfg_wr)
        begin
            case (cfg_sel)
                clut_pkg::REG_ADC_SHIFT: adc_shift_next = pwdata[clut_pkg::SHIFT_W-1:0];
                clut_pkg::REG_TDS_SHIFT: tds_shift_next = pwdata[clut_pkg::SHIFT_W-1:0];
                default:                 adc_shift_next = adc_shift_reg;
            endcase
        end
    end

    always_comb
    begin
        case (cfg_sel)
            clut_pkg::REG_ADC_SHIFT:
                prdata = clut_pkg::APB_DW'(adc_shift_reg);
            clut_pkg::REG_TDS_SHIFT:
                prdata = clut_pkg::APB_DW'(tds_shift_reg);
            default:
                prdata = '0;
        endcase
    end

    // ------------------------------------------------------------------
    // flops
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg      <= clut_pkg::ST_IDLE;
            primed_reg    <= 1'b0;
            adc_shift_reg <= clut_pkg::ADC_SHIFT_RST;
            tds_shift_reg <= clut_pkg::TDS_SHIFT_RST;
            adc_avg_reg   <= '0;
            tds_avg_reg   <= '0;
            out_valid_reg <= 1'b0;
            k_reg         <= '0;
            bit_reg       <= '0;
        end
        else
        begin
            step_reg      <= step_next;
            primed_reg    <= primed_next;
            adc_shift_reg <= adc_shift_next;
            tds_shift_reg <= tds_shift_next;
            adc_avg_reg   <= adc_avg_next;
            tds_avg_reg   <= tds_avg_next;
            out_valid_reg <= out_valid_next;
            k_reg         <= k_next;
            bit_reg       <= bit_next;
        end
    end

    always_ff @(posedge clk)
    begin
        sample_reg   <= sample_next;
        v_reg        <= v_next;
        seg_reg      <= seg_next;
        t0_reg       <= t0_next;
        dt_reg       <= dt_next;
        r_reg        <= r_next;
        den_reg      <= den_next;
        num_reg      <= num_next;
        quo_reg      <= quo_next;
        out_adc_reg  <= out_adc_next;
        out_tds_reg  <= out_tds_next;
        out_tavg_reg <= out_tavg_next;
        out_seg_reg  <= out_seg_next;
    end

    assign results.valid          = out_valid_reg;
    assign results.adc_average_q8 = out_adc_reg;
    assign results.tds_instant_q4 = out_tds_reg;
    assign results.tds_average_q4 = out_tavg_reg;
    assign results.segment_index  = out_seg_reg;

    // ------------------------------------------------------------------
    // checks
    // ------------------------------------------------------------------
    a_accept_starts_average: assert property (@(posedge clk) disable iff (!rst_n)
        in_fire |=> (step_reg == clut_pkg::ST_AVG))
        else $error("accepted item did not move to averaging");

    a_walk_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        (step_reg == clut_pkg::ST_SEARCH) |-> (k_reg <= LAST_SEG))
        else $error("segment walk ran past the last segment");

    a_emit_loads_output: assert property (@(posedge clk) disable iff (!rst_n)
        (en_emit && out_free) |=> (out_valid_reg && (step_reg == clut_pkg::ST_IDLE)))
        else $error("emit step did not fill the output register");

    a_result_segment: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> (out_seg_reg < LAST_ROW))
        else $error("result segment outside the table");

    a_result_tds_bounds: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> ((out_tds_reg >= TMIN_Q4) && (out_tds_reg <= TMAX_Q4)))
        else $error("instant tds outside the table span");

endmodule
